// File: design/uvpg_pkg.sv
// ----------------------------------------------------------------------------
// uvpg_pkg
// Shared types and constants for the UV point proximity grouping block.
// ----------------------------------------------------------------------------
package uvpg_pkg;

  localparam int unsigned MAX_POINTS      = 64;
  localparam int unsigned COORD_FRAC_BITS = 16;

  localparam int unsigned COORD_W  = COORD_FRAC_BITS + 1;
  localparam int unsigned THRESH_W = 2 * COORD_FRAC_BITS + 2;
  localparam int unsigned POINT_W  = 2 * COORD_W;
  localparam int unsigned SQ_W     = 2 * COORD_W;
  localparam int unsigned SUM_W    = SQ_W + 1;
  localparam int unsigned PTR_W    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W    = PTR_W + 1;
  localparam int unsigned IDX_W    = 6;

  // 0.0001 in the squared coordinate scale
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(429497);

  typedef struct packed {
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
    logic               set_end;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [IDX_W-1:0] group_index;
    logic             group_last;
    logic             run_last;
    logic             overflowed;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // store the accepted request
    logic lead_step;    // skip a taken leader slot
    logic lead_take;    // open a group at the leader slot
    logic leader_load;  // capture the leader point
    logic cand_step;    // skip a candidate
    logic diff_en;      // register coordinate differences
    logic mul_en;       // register squares
    logic cand_join;    // candidate joins the open group
    logic group_end;    // close the open group
    logic flush;        // release the final result, clear the set
  } uvpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic i_end;
    logic i_taken;
    logic j_end;
    logic j_taken;
    logic close;
    logic emit_ok;
    logic out_free;
  } uvpg_stat_t;

endpackage

// File: design/uv_point_proximity_grouping_top.sv
// ----------------------------------------------------------------------------
// uv_point_proximity_grouping_top
// Greedy leader grouping of 2D texture coordinates by squared distance.
// ----------------------------------------------------------------------------
// Points load one per cycle into a 64-entry store; a request with set_end
// starts grouping and the input stays blocked until the set's last result
// has been handed to the output register. The grouping pass is a single
// shared distance unit behind a sequencer: each untaken leader slot is sought
// and then read from the store, a leader slot already taken is skipped,
// each untaken later point goes through store read, difference, square
// and compare, and a later point already taken is skipped. Each group is
// closed once its candidate scan ends, and the final result is released
// once the leader scan ends. For a set of N points the distance tests
// number at most N(N-1)/2, and output back-pressure adds stalls. Results
// come out leader first, then joiners in load order.
module uv_point_proximity_grouping_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uvpg_pkg::THRESH_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  uvpg_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output uvpg_pkg::out_rsp_t            out_rsp_o
);
  import uvpg_pkg::*;

  uvpg_cmd_t  cmd;
  uvpg_stat_t stat;

  uvpg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_set_end_i (in_req_i.set_end),
    .in_ready_o   (in_ready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  uvpg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: design/uvpg_ram.sv
// ----------------------------------------------------------------------------
// uvpg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module uvpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/uvpg_ctrl.sv
// ----------------------------------------------------------------------------
// uvpg_ctrl
// Sequencer for loading a set and walking the leader and candidate scans.
// ----------------------------------------------------------------------------
module uvpg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_set_end_i,
  output logic                  in_ready_o,
  input  uvpg_pkg::uvpg_stat_t  stat_i,
  output uvpg_pkg::uvpg_cmd_t   cmd_o
);
  import uvpg_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_LEAD_SEEK = 3'd1;
  localparam logic [2:0] S_LEAD_WAIT = 3'd2;
  localparam logic [2:0] S_CAND_SEEK = 3'd3;
  localparam logic [2:0] S_CAND_DIFF = 3'd4;
  localparam logic [2:0] S_CAND_MUL  = 3'd5;
  localparam logic [2:0] S_CAND_CMP  = 3'd6;
  localparam logic [2:0] S_FLUSH     = 3'd7;

  logic [2:0] state_q, state_d;
  uvpg_cmd_t  cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          if (in_set_end_i) begin
            state_d = S_LEAD_SEEK;
          end
        end
      end
      S_LEAD_SEEK: begin
        if (stat_i.i_end) begin
          state_d = S_FLUSH;
        end else if (stat_i.i_taken) begin
          cmd.lead_step = 1'b1;
        end else if (stat_i.emit_ok) begin
          cmd.lead_take = 1'b1;
          state_d       = S_LEAD_WAIT;
        end
      end
      S_LEAD_WAIT: begin
        cmd.leader_load = 1'b1;
        state_d         = S_CAND_SEEK;
      end
      S_CAND_SEEK: begin
        if (stat_i.j_end) begin
          cmd.group_end = 1'b1;
          state_d       = S_LEAD_SEEK;
        end else if (stat_i.j_taken) begin
          cmd.cand_step = 1'b1;
        end else begin
          state_d = S_CAND_DIFF;
        end
      end
      S_CAND_DIFF: begin
        cmd.diff_en = 1'b1;
        state_d     = S_CAND_MUL;
      end
      S_CAND_MUL: begin
        cmd.mul_en = 1'b1;
        state_d    = S_CAND_CMP;
      end
      S_CAND_CMP: begin
        if (!stat_i.close) begin
          cmd.cand_step = 1'b1;
          state_d       = S_CAND_SEEK;
        end else if (stat_i.emit_ok) begin
          cmd.cand_join = 1'b1;
          state_d       = S_CAND_SEEK;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd.flush = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/uvpg_datapath.sv
// ----------------------------------------------------------------------------
// uvpg_datapath
// Point store, scan counters, taken marks, distance pipeline and result
// registers for the proximity grouping block.
// ----------------------------------------------------------------------------
module uvpg_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [uvpg_pkg::THRESH_W-1:0]    cfg_wdata_i,
  input  uvpg_pkg::in_req_t                in_req_i,
  input  uvpg_pkg::uvpg_cmd_t              cmd_i,
  output uvpg_pkg::uvpg_stat_t             stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output uvpg_pkg::out_rsp_t               out_rsp_o
);
  import uvpg_pkg::*;

  logic [THRESH_W-1:0]   thresh_q;
  logic [CNT_W-1:0]      count_q;
  logic                  ovf_q;
  logic [CNT_W-1:0]      i_q;
  logic [CNT_W-1:0]      j_q;
  logic [MAX_POINTS-1:0] taken_q;
  logic [IDX_W-1:0]      grp_q;
  logic                  pend_valid_q;
  out_rsp_t              pend_q;
  logic                  out_valid_q;
  out_rsp_t              out_q;

  logic [POINT_W-1:0]    leader_q;
  logic [COORD_W-1:0]    du_q, dv_q;
  logic [SQ_W-1:0]       squ_q, sqv_q;

  logic                  full;
  logic                  ram_we;
  logic [PTR_W-1:0]      raddr;
  logic [POINT_W-1:0]    rdata;
  logic [COORD_W-1:0]    lu, lv, cu, cv;
  logic [SUM_W-1:0]      dist_sq;
  logic                  out_free;
  logic                  emit;
  logic                  push;
  out_rsp_t              new_rsp;
  out_rsp_t              last_rsp;

  assign full   = (count_q == CNT_W'(MAX_POINTS));
  assign ram_we = cmd_i.load && !full;
  assign raddr  = cmd_i.lead_take ? i_q[PTR_W-1:0] : j_q[PTR_W-1:0];

  uvpg_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[PTR_W-1:0]),
    .wdata_i ({in_req_i.coord_v, in_req_i.coord_u}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign lu = leader_q[COORD_W-1:0];
  assign lv = leader_q[POINT_W-1:COORD_W];
  assign cu = rdata[COORD_W-1:0];
  assign cv = rdata[POINT_W-1:COORD_W];

  assign dist_sq = SUM_W'(squ_q) + SUM_W'(sqv_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cmd_i.lead_take || cmd_i.cand_join;
  assign push     = (emit && pend_valid_q) || cmd_i.flush;

  always_comb begin
    new_rsp             = '0;
    new_rsp.point_index = cmd_i.lead_take ? IDX_W'(i_q[PTR_W-1:0])
                                          : IDX_W'(j_q[PTR_W-1:0]);
    new_rsp.group_index = grp_q;
    new_rsp.overflowed  = ovf_q;
  end

  // final result of the set closes its group and the run
  always_comb begin
    last_rsp            = pend_q;
    last_rsp.group_last = 1'b1;
    last_rsp.run_last   = 1'b1;
  end

  assign stat_o.i_end    = (i_q >= count_q);
  assign stat_o.i_taken  = taken_q[i_q[PTR_W-1:0]];
  assign stat_o.j_end    = (j_q >= count_q);
  assign stat_o.j_taken  = taken_q[j_q[PTR_W-1:0]];
  assign stat_o.close    = (dist_sq < SUM_W'(thresh_q));
  assign stat_o.emit_ok  = !pend_valid_q || out_free;
  assign stat_o.out_free = out_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q     <= THRESH_RESET;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      taken_q      <= '0;
      grp_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.lead_step || cmd_i.group_end) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.lead_take) begin
        taken_q[i_q[PTR_W-1:0]] <= 1'b1;
        j_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.cand_step || cmd_i.cand_join) begin
        j_q <= j_q + CNT_W'(1);
      end
      if (cmd_i.cand_join) begin
        taken_q[j_q[PTR_W-1:0]] <= 1'b1;
      end
      if (cmd_i.group_end) begin
        grp_q <= grp_q + IDX_W'(1);
      end
      if (emit) begin
        pend_valid_q <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        count_q      <= '0;
        ovf_q        <= 1'b0;
        i_q          <= '0;
        taken_q      <= '0;
        grp_q        <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.leader_load) begin
      leader_q <= rdata;
    end
    if (cmd_i.diff_en) begin
      du_q <= (lu >= cu) ? (lu - cu) : (cu - lu);
      dv_q <= (lv >= cv) ? (lv - cv) : (cv - lv);
    end
    if (cmd_i.mul_en) begin
      squ_q <= SQ_W'(du_q) * SQ_W'(du_q);
      sqv_q <= SQ_W'(dv_q) * SQ_W'(dv_q);
    end
    if (emit) begin
      pend_q <= new_rsp;
    end else if (cmd_i.group_end) begin
      pend_q.group_last <= 1'b1;
    end
    if (push) begin
      out_q <= cmd_i.flush ? last_rsp : pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: design/uvpg_checker.sv
// ----------------------------------------------------------------------------
// uvpg_checker
// Port-level checks for the proximity grouping block, bound to the top.
// ----------------------------------------------------------------------------
module uvpg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input uvpg_pkg::in_req_t             in_req_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input uvpg_pkg::out_rsp_t            out_rsp_o
);
  import uvpg_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  // grouping blocks the input right after the closing request
  a_set_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.set_end |=> !in_ready_o)
    else $error("input still open after set end");

  // input closes only on a closing request
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_req_i.set_end))
    else $error("input closed without set end");

  // the final result of a set also ends its group
  a_run_last_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.run_last |-> out_rsp_o.group_last)
    else $error("run end without group end");

endmodule

bind uv_point_proximity_grouping_top uvpg_checker u_checker (.*);
